@@ rtl/lavm_pkg.sv @@
// Shared constants for the look-at view matrix datapath.
// No dependencies; imported by lavm_unit and look_at_view_matrix.
package lavm_pkg;

  localparam int NORM_STAGES = 6;
  localparam int SQ_STEPS    = 32;
  localparam int DV_STEPS    = 31;
  localparam int UNIT_LAT    = NORM_STAGES + SQ_STEPS + DV_STEPS + 2;

  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_UP_X = 2'd0;
  localparam logic [CFG_AW-1:0] REG_UP_Y = 2'd1;
  localparam logic [CFG_AW-1:0] REG_UP_Z = 2'd2;

  localparam logic signed [31:0] UP_X_RST = 32'sd0;
  localparam logic signed [31:0] UP_Y_RST = 32'sd65536;
  localparam logic signed [31:0] UP_Z_RST = 32'sd0;

  localparam logic signed [31:0] ONE_Q30  = 32'sh4000_0000;
  localparam logic [55:0]        SMALL_SQ = 56'd4611686018427388;

endpackage

@@ rtl/lavm_delay.sv @@
// Payload delay line with a shared advance enable.
// Depends on nothing; used by the top level to align operands.
module lavm_delay #(
  parameter int W = 32,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         ce,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [N];

  always_ff @(posedge clk) begin
    if (ce) begin
      line[0] <= din;
      for (int k = 1; k < N; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign dout = line[N-1];

endmodule

@@ rtl/lavm_unit.sv @@
// Pipelined vector normalize: block scale, sum of squares, bit-serial
// square root and restoring divide, one step per stage. Uses lavm_pkg.
module lavm_unit
  import lavm_pkg::*;
#(
  parameter int W = 64
) (
  input  logic                clk,
  input  logic                ce,
  input  logic signed [W-1:0] vin [3],
  output logic signed [31:0]  u [3],
  output logic                ok
);

  localparam int NG = (W + 7) / 8;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;
  localparam int SW = GW + 3;
  localparam int WP = NG * 8;

  typedef struct packed {
    logic [2:0][30:0] nm;
    logic [2:0]       neg;
    logic             zero;
  } car_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
    car_t        car;
  } sq_t;

  typedef struct packed {
    logic [2:0][61:0] rem;
    logic [2:0][30:0] q;
    logic [31:0]      len;
    logic [2:0]       neg;
    logic             zero;
  } dv_t;

  logic [W-1:0]  mag1 [3];
  logic [2:0]    neg1;
  logic [W-1:0]  mag2 [3];
  logic [2:0]    neg2;
  logic [NG-1:0] gnz2;
  logic [2:0]    glo2 [NG];
  logic [W-1:0]  mag3 [3];
  logic [2:0]    neg3;
  logic [SW-1:0] msb3;
  logic          zero3;
  car_t          c4, c5, c6;
  logic [61:0]   sq5 [3];
  logic [63:0]   s6;

  logic [WP-1:0] orp;
  logic [NG-1:0] gnz;
  logic [2:0]    glo [NG];
  logic [SW-1:0] msb;
  logic          zero;
  car_t          c4_next;
  logic [W-1:0]  shv;

  sq_t sq [SQ_STEPS];
  sq_t sq_in [SQ_STEPS];
  sq_t sq_next [SQ_STEPS];
  dv_t dv0, dv0_next;
  dv_t dv [DV_STEPS];
  dv_t dv_in [DV_STEPS];
  dv_t dv_next [DV_STEPS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
    end
    orp = WP'(mag1[0] | mag1[1] | mag1[2]);
    for (int g = 0; g < NG; g++) begin
      gnz[g] = |orp[g*8 +: 8];
      glo[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (orp[g*8 + b]) glo[g] = 3'(b);
      end
    end
  end

  always_comb begin
    msb  = '0;
    zero = 1'b1;
    for (int g = 0; g < NG; g++) begin
      if (gnz2[g]) begin
        msb  = SW'(g * 8) + SW'(glo2[g]);
        zero = 1'b0;
      end
    end
  end

  always_comb begin
    c4_next.neg  = neg3;
    c4_next.zero = zero3;
    for (int i = 0; i < 3; i++) begin
      if (msb3 >= SW'(30)) shv = mag3[i] >> (msb3 - SW'(30));
      else shv = mag3[i] << (SW'(30) - msb3);
      c4_next.nm[i] = shv[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= vin[i][W-1] ? W'(-vin[i]) : W'(vin[i]);
        neg1[i] <= vin[i][W-1];
        mag2[i] <= mag1[i];
        mag3[i] <= mag2[i];
        sq5[i]  <= c4.nm[i] * c4.nm[i];
      end
      neg2 <= neg1;
      gnz2 <= gnz;
      for (int g = 0; g < NG; g++) begin
        glo2[g] <= glo[g];
      end
      neg3  <= neg2;
      msb3  <= msb;
      zero3 <= zero;
      c4    <= c4_next;
      c5    <= c4;
      c6    <= c5;
      s6    <= 64'(sq5[0]) + 64'(sq5[1]) + 64'(sq5[2]);
    end
  end

  // square root, one result bit per stage
  always_comb begin
    logic [63:0] bitv;
    logic [63:0] trial;
    sq_in[0].rem  = s6;
    sq_in[0].root = '0;
    sq_in[0].car  = c6;
    for (int k = 1; k < SQ_STEPS; k++) begin
      sq_in[k] = sq[k-1];
    end
    for (int k = 0; k < SQ_STEPS; k++) begin
      bitv  = 64'd1 << (62 - 2 * k);
      trial = sq_in[k].root + bitv;
      sq_next[k].car = sq_in[k].car;
      if (sq_in[k].rem >= trial) begin
        sq_next[k].rem  = sq_in[k].rem - trial;
        sq_next[k].root = (sq_in[k].root >> 1) + bitv;
      end else begin
        sq_next[k].rem  = sq_in[k].rem;
        sq_next[k].root = sq_in[k].root >> 1;
      end
    end
  end

  always_comb begin
    dv0_next.len  = sq[SQ_STEPS-1].root[31:0];
    dv0_next.neg  = sq[SQ_STEPS-1].car.neg;
    dv0_next.zero = sq[SQ_STEPS-1].car.zero;
    dv0_next.q    = '0;
    for (int i = 0; i < 3; i++) begin
      dv0_next.rem[i] = {sq[SQ_STEPS-1].car.nm[i], 31'd0} >> 1;
      dv0_next.rem[i] = dv0_next.rem[i] + 62'(dv0_next.len >> 1);
    end
  end

  // restoring divide, one quotient bit per stage
  always_comb begin
    logic [61:0] dsub;
    dv_in[0] = dv0;
    for (int j = 1; j < DV_STEPS; j++) begin
      dv_in[j] = dv[j-1];
    end
    for (int j = 0; j < DV_STEPS; j++) begin
      dv_next[j] = dv_in[j];
      dsub = 62'(dv_in[j].len) << (DV_STEPS - 1 - j);
      for (int i = 0; i < 3; i++) begin
        if (dv_in[j].rem[i] >= dsub) begin
          dv_next[j].rem[i] = dv_in[j].rem[i] - dsub;
          dv_next[j].q[i]   = {dv_in[j].q[i][29:0], 1'b1};
        end else begin
          dv_next[j].q[i]   = {dv_in[j].q[i][29:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] c;
    if (ce) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        sq[k] <= sq_next[k];
      end
      dv0 <= dv0_next;
      for (int j = 0; j < DV_STEPS; j++) begin
        dv[j] <= dv_next[j];
      end
      for (int i = 0; i < 3; i++) begin
        c = (dv[DV_STEPS-1].q[i] > 31'(ONE_Q30)) ? ONE_Q30 : {1'b0, dv[DV_STEPS-1].q[i]};
        if (dv[DV_STEPS-1].zero) u[i] <= '0;
        else if (dv[DV_STEPS-1].neg[i]) u[i] <= -$signed(c);
        else u[i] <= $signed(c);
      end
      ok <= !dv[DV_STEPS-1].zero;
    end
  end

endmodule

@@ rtl/look_at_view_matrix.sv @@
// Look-at view matrix pipeline; uses lavm_pkg, lavm_unit and lavm_delay.
// Four normalize units of 71 stages each, set by the 32-step square root and
// 31-step divide, form the datapath. Throughput: one word per cycle while the
// skid is empty; a two-word output skid keeps s_tready off the m_tready path.
// Reset clears the valid pipeline, output and skid valids, and loads the up
// vector with (0, 1.0, 0).
module look_at_view_matrix
  import lavm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [31:0]       cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [191:0]      s_tdata,  // pos_x, pos_y, pos_z, target_x, target_y, target_z
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [383:0]      m_tdata   // right_x..z, upaxis_x..z, back_x..z, shift_x..z
);

  localparam int T_R    = 3;
  localparam int T_TR   = T_R + UNIT_LAT + 1;
  localparam int T_DU   = T_TR + 2;
  localparam int T_Z    = T_DU + UNIT_LAT;
  localparam int T_X    = T_Z + 2 + UNIT_LAT;
  localparam int T_Y    = T_X + 3;
  localparam int T_LAST = T_Y + 3;
  localparam int NX1 [3] = '{1, 2, 0};
  localparam int NX2 [3] = '{2, 0, 1};

  logic              ce;
  logic signed [31:0] up [3];
  logic [T_LAST-1:0] vld;
  logic              v_last;
  logic              skid_valid;
  logic [383:0]      skid;
  logic [383:0]      res;

  logic signed [31:0] pin [3];
  logic signed [32:0] f0 [3], nf0 [3];
  logic signed [31:0] hu0 [3];
  logic [32:0]        hs [3];
  logic signed [31:0] p1 [3], hu1 [3];
  logic signed [32:0] f1 [3], nf1 [3];
  logic signed [64:0] pa2 [3], pb2 [3];
  logic signed [63:0] r3 [3];

  logic [2:0]   lt0, lt4;
  logic [26:0]  a0 [3], a4 [3];
  logic [53:0]  sq5 [3];
  logic         all5, small6, small_d;

  logic signed [31:0] tr_u [3], tr [3];
  logic [98:0]        f_d, nf_d;
  logic signed [32:0] f_t [3], nf_t [3];
  logic signed [64:0] qa [3], qb [3];
  logic signed [63:0] du [3];
  logic signed [31:0] dun [3], z [3], x [3];
  logic               z_ok, x_ok;
  logic signed [63:0] ca [3], cb [3], xr [3];
  logic [96:0]        z_d;
  logic signed [31:0] zz [3];
  logic signed [63:0] ya [3], yb [3], yp [3];
  logic signed [63:0] ysum [3];
  logic signed [33:0] yr [3];
  logic signed [31:0] y [3];
  logic [191:0]       xz_d;
  logic [95:0]        p_d;
  logic signed [31:0] ax [3][3];
  logic signed [31:0] pt [3];
  logic signed [63:0] dp [3][3];
  logic signed [65:0] dsum [3];
  logic signed [65:0] dr [3];
  logic signed [35:0] rd [3];
  logic [287:0]       ax_d;
  logic               ok_d;
  logic signed [36:0] nr [3];
  logic [31:0]        sh [3];

  assign ce       = !skid_valid;
  assign s_tready = ce;
  assign v_last   = vld[T_LAST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      up[0] <= UP_X_RST;
      up[1] <= UP_Y_RST;
      up[2] <= UP_Z_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_UP_X: up[0] <= cfg_data;
        REG_UP_Y: up[1] <= cfg_data;
        REG_UP_Z: up[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (ce) vld <= {vld[T_LAST-2:0], s_tvalid};
  end

  // forward, back and halved up
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pin[i] = s_tdata[32*i +: 32];
      f0[i]  = {s_tdata[96+32*i+31], s_tdata[96+32*i +: 32]} - {pin[i][31], pin[i]};
      nf0[i] = {pin[i][31], pin[i]} - {s_tdata[96+32*i+31], s_tdata[96+32*i +: 32]};
      hs[i]  = {up[i][31], up[i]} + {32'd0, up[i][31]};
      hu0[i] = hs[i][32:1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lt0[i] = (r3[i][63:27] == '0) || ((&r3[i][63:27]) && (r3[i][26:0] != '0));
      a0[i]  = r3[i][63] ? 27'(-r3[i][26:0]) : r3[i][26:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        p1[i]  <= pin[i];
        f1[i]  <= f0[i];
        nf1[i] <= nf0[i];
        hu1[i] <= hu0[i];
        pa2[i] <= hu1[NX1[i]] * f1[NX2[i]];
        pb2[i] <= hu1[NX2[i]] * f1[NX1[i]];
        r3[i]  <= 64'(pa2[i] - pb2[i]);
        a4[i]  <= a0[i];
        sq5[i] <= a4[i] * a4[i];
      end
      lt4    <= lt0;
      all5   <= &lt4;
      small6 <= all5 && ((56'(sq5[0]) + 56'(sq5[1]) + 56'(sq5[2])) < SMALL_SQ);
    end
  end

  lavm_unit #(.W(64)) u_right (.clk(clk), .ce(ce), .vin(r3), .u(tr_u), .ok());

  lavm_delay #(.W(1), .N(T_R + UNIT_LAT - 6)) u_small_dly (
    .clk(clk), .ce(ce), .din(small6), .dout(small_d));
  lavm_delay #(.W(99), .N(T_TR - 1)) u_f_dly (
    .clk(clk), .ce(ce), .din({f1[2], f1[1], f1[0]}), .dout(f_d));
  lavm_delay #(.W(99), .N(T_DU - 1)) u_nf_dly (
    .clk(clk), .ce(ce), .din({nf1[2], nf1[1], nf1[0]}), .dout(nf_d));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_t[i]  = f_d[33*i +: 33];
      nf_t[i] = nf_d[33*i +: 33];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        if (small_d) tr[i] <= (i == 0) ? ONE_Q30 : '0;
        else tr[i] <= tr_u[i];
        qa[i] <= f_t[NX1[i]] * tr[NX2[i]];
        qb[i] <= f_t[NX2[i]] * tr[NX1[i]];
        du[i] <= 64'(qa[i] - qb[i]);
      end
    end
  end

  lavm_unit #(.W(64)) u_adj (.clk(clk), .ce(ce), .vin(du), .u(dun), .ok());
  lavm_unit #(.W(33)) u_back (.clk(clk), .ce(ce), .vin(nf_t), .u(z), .ok(z_ok));

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        ca[i] <= dun[NX1[i]] * z[NX2[i]];
        cb[i] <= dun[NX2[i]] * z[NX1[i]];
        xr[i] <= ca[i] - cb[i];
      end
    end
  end

  lavm_unit #(.W(64)) u_xaxis (.clk(clk), .ce(ce), .vin(xr), .u(x), .ok(x_ok));

  lavm_delay #(.W(97), .N(UNIT_LAT + 2)) u_z_dly (
    .clk(clk), .ce(ce), .din({z_ok, z[2], z[1], z[0]}), .dout(z_d));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      zz[i]   = z_d[32*i +: 32];
      ysum[i] = yp[i] + 64'sd536870912 - $signed({63'd0, yp[i][63]});
      yr[i]   = ysum[i][63:30];
    end
  end

  // up axis, rounded half away from zero and clamped
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        ya[i] <= zz[NX1[i]] * x[NX2[i]];
        yb[i] <= zz[NX2[i]] * x[NX1[i]];
        yp[i] <= ya[i] - yb[i];
        if (yr[i] > 34'sd1073741824) y[i] <= ONE_Q30;
        else if (yr[i] < -34'sd1073741824) y[i] <= -ONE_Q30;
        else y[i] <= yr[i][31:0];
      end
    end
  end

  lavm_delay #(.W(192), .N(3)) u_xz_dly (
    .clk(clk), .ce(ce), .din({zz[2], zz[1], zz[0], x[2], x[1], x[0]}), .dout(xz_d));
  lavm_delay #(.W(96), .N(T_Y - 1)) u_p_dly (
    .clk(clk), .ce(ce), .din({p1[2], p1[1], p1[0]}), .dout(p_d));
  lavm_delay #(.W(1), .N(T_LAST - T_X)) u_ok_dly (
    .clk(clk), .ce(ce), .din(x_ok && z_d[96]), .dout(ok_d));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax[0][i] = xz_d[32*i +: 32];
      ax[1][i] = y[i];
      ax[2][i] = xz_d[96+32*i +: 32];
      pt[i]    = p_d[32*i +: 32];
    end
    for (int k = 0; k < 3; k++) begin
      dr[k] = dsum[k] + 66'sd536870912 - $signed({65'd0, dsum[k][65]});
    end
  end

  lavm_delay #(.W(288), .N(3)) u_ax_dly (
    .clk(clk), .ce(ce),
    .din({ax[2][2], ax[2][1], ax[2][0], ax[1][2], ax[1][1], ax[1][0],
          ax[0][2], ax[0][1], ax[0][0]}),
    .dout(ax_d));

  // translation: dot with position, round, negate, saturate
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          dp[k][i] <= ax[k][i] * pt[i];
        end
        dsum[k] <= dp[k][0] + dp[k][1] + dp[k][2];
        rd[k]   <= dr[k][65:30];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nr[k] = -{rd[k][35], rd[k]};
      if (nr[k] > 37'sd2147483647) sh[k] = 32'h7fff_ffff;
      else if (nr[k] < -37'sd2147483648) sh[k] = 32'h8000_0000;
      else sh[k] = nr[k][31:0];
    end
    res = ok_d ? {sh[2], sh[1], sh[0], ax_d} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= v_last;
    end else if (v_last) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) m_tdata <= skid;
    end else if (!m_tvalid || m_tready) begin
      if (v_last) m_tdata <= res;
    end else if (v_last) begin
      skid <= res;
    end
  end

  a_skid_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid word held with no output word");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid filled while output was free");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vld))
    else $error("pipeline moved during stall");

endmodule
